// ===== src/assert_macros.svh =====
// Assertion macros shared by the step sequencer RTL.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/mtss_pkg.sv =====
// Package for the multi-track step sequencer: item types, command codes,
// state encoding and reset defaults. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mtss_pkg;

   localparam int TRACKS_DEF = 4;
   localparam int STEPS_DEF  = 8;
   localparam int NUM_CFG    = 4;

   localparam logic [13:0] DEF_VALUE  = 14'd0;
   localparam logic [7:0]  DEF_TICKS  = 8'd24;
   localparam logic [7:0]  DEF_GATE   = 8'd18;
   localparam logic [3:0]  DEF_LENGTH = 4'd8;

   localparam logic [2:0] OP_START = 3'd0;
   localparam logic [2:0] OP_STOP  = 3'd1;
   localparam logic [2:0] OP_CONT  = 3'd2;
   localparam logic [2:0] OP_GET   = 3'd3;
   localparam logic [2:0] OP_SET   = 3'd4;
   localparam logic [2:0] OP_TICK  = 3'd5;

   localparam logic KIND_STARTED  = 1'b0;
   localparam logic KIND_CONTENTS = 1'b1;

   typedef struct packed {
      logic [2:0]  op;
      logic [1:0]  track_id;
      logic [2:0]  step_id;
      logic [13:0] step_value;
      logic [7:0]  step_ticks;
      logic [7:0]  step_gate;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [1:0]  out_track;
      logic [2:0]  out_step;
      logic [13:0] out_value;
      logic [7:0]  out_ticks;
      logic [7:0]  out_gate;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [13:0] value;
      logic [7:0]  ticks;
      logic [7:0]  gate;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TRD,
      ST_TEV,
      ST_TFL,
      ST_GRD
   } state_type;

endpackage

`default_nettype wire

// ===== src/mtss_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the step entry and step counter stores.
`timescale 1ns / 1ps
`default_nettype none

module mtss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== src/multi_track_step_sequencer_unit.sv =====
// Top level of the multi-track step sequencer: command decode, tick walk
// over the tracks and report output. Depends on mtss_pkg, mtss_ram and
// assert_macros.svh.
//
//   Port group   Direction   Handshake          Item
//   req_*        in          valid / stall      one command (req_type)
//   rsp_*        out         valid / stall      one report (rsp_type)
//   csr_*        in          valid / ready      track length write
//
// Start, stop, continue and set step are done when accepted; get step
// reports from ST_GRD. A tick while running walks the tracks: ST_TRD
// addresses each track's step memories; ST_TEV evaluates, writes back.
// Reset is synchronous; no clearing pass is needed, since per-entry valid
// bits make unwritten entries read as their defaults.
// A stalled report output holds the tick walk only when a further report
// is ready to leave; one report waits in a holding register so that the
// final one of a tick can be marked.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module multi_track_step_sequencer_unit #(
   parameter int TRACKS = mtss_pkg::TRACKS_DEF,
   parameter int STEPS  = mtss_pkg::STEPS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire mtss_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output mtss_pkg::rsp_type     rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [1:0]       csr_index,
   input  wire logic [3:0]       csr_wdata
);

   localparam int DEPTH = TRACKS * STEPS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW    = $clog2(STEPS);
   localparam int TKW   = (TRACKS > 1) ? $clog2(TRACKS) : 1;

   mtss_pkg::state_type state_ff, state_in;
   logic                running_ff, running_in;
   logic [PW-1:0]       pos_ff [TRACKS];
   logic [PW-1:0]       pos_in [TRACKS];
   logic [3:0]          len_ff [TRACKS];
   logic [3:0]          len_in [TRACKS];
   logic [TKW-1:0]      trk_ff, trk_in;
   logic [2:0]          step_ff, step_in;
   logic [AW-1:0]       addr_ff, addr_in;
   logic [DEPTH-1:0]    ent_vld_ff, ent_vld_in;
   logic [DEPTH-1:0]    cnt_vld_ff, cnt_vld_in;
   logic                hold_vld_ff, hold_vld_in;
   mtss_pkg::rsp_type   hold_ff, hold_in;
   logic                rsp_valid_ff;
   mtss_pkg::rsp_type   rsp_data_ff;

   logic                out_load;
   mtss_pkg::rsp_type   out_data;
   logic                slot_free;

   logic                   ent_we;
   mtss_pkg::entry_type    ent_wdata;
   mtss_pkg::entry_type    ent_rdata;
   logic                   cnt_we;
   logic [7:0]             cnt_rdata;

   mtss_pkg::entry_type ent_cur;
   logic [7:0]          cnt_cur;
   logic [7:0]          cnt_dec;
   logic                emit;
   logic [PW-1:0]       pos_cur;
   logic [PW-1:0]       p_eff;
   logic [7:0]          p_inc;
   logic [7:0]          len_raw;
   logic [7:0]          len_eff;
   logic [PW-1:0]       pos_next;
   logic [AW-1:0]       tick_addr;
   logic [AW-1:0]       req_addr;
   logic                get_ok;
   logic                accept;
   mtss_pkg::rsp_type   tick_rep;
   mtss_pkg::rsp_type   get_rep;

   mtss_ram #(
      .WIDTH ($bits(mtss_pkg::entry_type)),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (req_addr),
      .wr_data (ent_wdata),
      .rd_addr (addr_in),
      .rd_data (ent_rdata)
   );

   mtss_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (addr_ff),
      .wr_data (cnt_dec),
      .rd_addr (addr_in),
      .rd_data (cnt_rdata)
   );

   assign req_stall = (state_ff != mtss_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign get_ok   = (int'(req_data.track_id) < TRACKS) && (int'(req_data.step_id) < STEPS);
   assign req_addr = AW'(int'(req_data.track_id) * STEPS + int'(req_data.step_id));

   // Entries never written read as their reset values; a counter without
   // its valid bit equals the step's duration (after reset, start, set step or reload).
   always_comb begin
      if (ent_vld_ff[addr_ff]) begin
         ent_cur = ent_rdata;
      end else begin
         ent_cur.value = mtss_pkg::DEF_VALUE;
         ent_cur.ticks = mtss_pkg::DEF_TICKS;
         ent_cur.gate  = mtss_pkg::DEF_GATE;
      end
      cnt_cur = cnt_vld_ff[addr_ff] ? cnt_rdata : ent_cur.ticks;
   end

   assign cnt_dec = cnt_cur - 8'd1;
   assign emit    = (cnt_cur == ent_cur.ticks);

   assign pos_cur   = pos_ff[trk_ff];
   assign p_eff     = (8'(pos_cur) >= 8'(STEPS)) ? '0 : pos_cur;
   assign p_inc     = 8'(p_eff) + 8'd1;
   assign len_raw   = 8'(len_ff[trk_ff]);
   assign len_eff   = (len_raw > 8'(STEPS)) ? 8'(STEPS) : len_raw;
   assign pos_next  = (p_inc >= len_eff) ? '0 : PW'(p_inc);
   assign tick_addr = AW'(int'(trk_ff) * STEPS + int'(p_eff));

   always_comb begin
      tick_rep.kind      = mtss_pkg::KIND_STARTED;
      tick_rep.out_track = 2'(trk_ff);
      tick_rep.out_step  = 3'(p_eff);
      tick_rep.out_value = ent_cur.value;
      tick_rep.out_ticks = ent_cur.ticks;
      tick_rep.out_gate  = ent_cur.gate;
      tick_rep.last      = 1'b0;

      get_rep.kind      = mtss_pkg::KIND_CONTENTS;
      get_rep.out_track = 2'(trk_ff);
      get_rep.out_step  = step_ff;
      get_rep.out_value = ent_cur.value;
      get_rep.out_ticks = ent_cur.ticks;
      get_rep.out_gate  = ent_cur.gate;
      get_rep.last      = 1'b1;
   end

   always_comb begin
      state_in    = state_ff;
      running_in  = running_ff;
      pos_in      = pos_ff;
      len_in      = len_ff;
      trk_in      = trk_ff;
      step_in     = step_ff;
      addr_in     = addr_ff;
      ent_vld_in  = ent_vld_ff;
      cnt_vld_in  = cnt_vld_ff;
      hold_vld_in = hold_vld_ff;
      hold_in     = hold_ff;
      out_load    = 1'b0;
      out_data    = hold_ff;
      ent_we      = 1'b0;
      cnt_we      = 1'b0;

      ent_wdata.value = req_data.step_value;
      ent_wdata.ticks = req_data.step_ticks;
      ent_wdata.gate  = req_data.step_gate;

      for (int t = 0; t < TRACKS; t++) begin
         if (csr_valid && t < mtss_pkg::NUM_CFG && int'(csr_index) == t) begin
            len_in[t] = csr_wdata;
         end
      end

      unique case (state_ff)
         mtss_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_data.op)
                  mtss_pkg::OP_START: begin
                     running_in = 1'b1;
                     cnt_vld_in = '0;
                     for (int t = 0; t < TRACKS; t++) begin
                        pos_in[t] = '0;
                     end
                  end
                  mtss_pkg::OP_STOP: begin
                     running_in = 1'b0;
                  end
                  mtss_pkg::OP_CONT: begin
                     running_in = 1'b1;
                  end
                  mtss_pkg::OP_GET: begin
                     if (get_ok) begin
                        addr_in  = req_addr;
                        trk_in   = TKW'(req_data.track_id);
                        step_in  = req_data.step_id;
                        state_in = mtss_pkg::ST_GRD;
                     end
                  end
                  mtss_pkg::OP_SET: begin
                     if (get_ok) begin
                        ent_we               = 1'b1;
                        ent_vld_in[req_addr] = 1'b1;
                        cnt_vld_in[req_addr] = 1'b0;
                     end
                  end
                  mtss_pkg::OP_TICK: begin
                     if (running_ff) begin
                        trk_in   = '0;
                        state_in = mtss_pkg::ST_TRD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         mtss_pkg::ST_TRD: begin
            addr_in  = tick_addr;
            state_in = mtss_pkg::ST_TEV;
         end
         mtss_pkg::ST_TEV: begin
            // A new report pushes the held one out, so it needs a free slot.
            if (!emit || !hold_vld_ff || slot_free) begin
               if (emit) begin
                  if (hold_vld_ff) begin
                     out_load = 1'b1;
                     out_data = hold_ff;
                  end
                  hold_vld_in = 1'b1;
                  hold_in     = tick_rep;
               end
               if (cnt_dec == 8'd0) begin
                  cnt_vld_in[addr_ff] = 1'b0;
                  pos_in[trk_ff]      = pos_next;
               end else begin
                  cnt_we              = 1'b1;
                  cnt_vld_in[addr_ff] = 1'b1;
                  pos_in[trk_ff]      = p_eff;
               end
               if (trk_ff == TKW'(TRACKS - 1)) begin
                  state_in = mtss_pkg::ST_TFL;
               end else begin
                  trk_in   = trk_ff + 1'b1;
                  state_in = mtss_pkg::ST_TRD;
               end
            end
         end
         mtss_pkg::ST_TFL: begin
            if (!hold_vld_ff) begin
               state_in = mtss_pkg::ST_IDLE;
            end else if (slot_free) begin
               out_load      = 1'b1;
               out_data      = hold_ff;
               out_data.last = 1'b1;
               hold_vld_in   = 1'b0;
               state_in      = mtss_pkg::ST_IDLE;
            end
         end
         mtss_pkg::ST_GRD: begin
            if (slot_free) begin
               out_load = 1'b1;
               out_data = get_rep;
               state_in = mtss_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mtss_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mtss_pkg::ST_IDLE;
         running_ff   <= 1'b0;
         ent_vld_ff   <= '0;
         cnt_vld_ff   <= '0;
         hold_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int t = 0; t < TRACKS; t++) begin
            pos_ff[t] <= '0;
            len_ff[t] <= mtss_pkg::DEF_LENGTH;
         end
      end else begin
         state_ff    <= state_in;
         running_ff  <= running_in;
         ent_vld_ff  <= ent_vld_in;
         cnt_vld_ff  <= cnt_vld_in;
         hold_vld_ff <= hold_vld_in;
         pos_ff      <= pos_in;
         len_ff      <= len_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      trk_ff  <= trk_in;
      step_ff <= step_in;
      addr_ff <= addr_in;
      hold_ff <= hold_in;
      if (out_load) begin
         rsp_data_ff <= out_data;
      end
   end

   `ASSERT_IMPLIES(a_hold_in_tick, clock, reset, hold_vld_ff, state_ff == mtss_pkg::ST_TEV || state_ff == mtss_pkg::ST_TRD || state_ff == mtss_pkg::ST_TFL, "held report outside a tick walk")
   `ASSERT_NEXT(a_get_reads, clock, reset, accept && req_data.op == mtss_pkg::OP_GET && get_ok, state_ff == mtss_pkg::ST_GRD, "get step did not start a read")
   `ASSERT_IMPLIES(a_contents_last, clock, reset, rsp_valid_ff && rsp_data_ff.kind == mtss_pkg::KIND_CONTENTS, rsp_data_ff.last, "contents report not marked final")

endmodule

`default_nettype wire
